### hw/rtl/sspg_pkg.sv
// Shared types and constants of the step/direction pulse generator.
// No dependencies.
package sspg_pkg;

  typedef enum logic [2:0] {
    OpTick    = 3'd0,
    OpMove    = 3'd1,
    OpStop    = 3'd2,
    OpEnable  = 3'd3,
    OpDisable = 3'd4
  } op_e;

  localparam int unsigned DpsW    = 16;
  localparam int unsigned RpmW    = 16;
  localparam int unsigned DispW   = 32;
  localparam int unsigned StepW   = 31;
  localparam int unsigned TimerW  = 32;
  localparam int unsigned DivNw   = 34;  // dividend and quotient
  localparam int unsigned DivDw   = 18;  // divisor
  localparam int unsigned DivCntW = $clog2(DivNw + 1);
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [DpsW-1:0]  DpsReset = 16'd180;
  localparam logic [DivNw-1:0] PerNum   = 34'd250000;

  localparam logic [ApbAddrW-3:0] RegDps = '0;

  typedef struct packed {
    logic             done;
    logic [DivNw-1:0] quot;
  } div_res_t;

endpackage

### hw/rtl/sspg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sspg_pkg.
module sspg_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sspg_pkg::DivNw-1:0] dividend_i,
  input  logic [sspg_pkg::DivDw-1:0] divisor_i,
  output sspg_pkg::div_res_t         res_o
);
  import sspg_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivNw-1:0]   acc_q, acc_d;
  logic [DivDw-1:0]   rem_q, rem_d;
  logic [DivDw-1:0]   dvs_q, dvs_d;
  logic [DivDw:0]     trial;
  logic [DivDw+1:0]   diff;

  assign trial = {rem_q, acc_q[DivNw-1]};
  assign diff  = {1'b0, trial} - {2'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivNw);
      acc_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (diff[DivDw+1]) begin
        rem_d = trial[DivDw-1:0];
        acc_d = {acc_q[DivNw-2:0], 1'b0};
      end else begin
        rem_d = diff[DivDw-1:0];
        acc_d = {acc_q[DivNw-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = acc_q;

endmodule

### hw/rtl/sspg_apb.sv
// APB register slave holding degrees-per-step.
// Depends on sspg_pkg.
module sspg_apb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sspg_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [sspg_pkg::DpsW-1:0]     dps_o
);
  import sspg_pkg::*;

  logic [DpsW-1:0] dps_q;
  logic            sel_dps;

  assign pready  = 1'b1;
  assign sel_dps = (paddr[ApbAddrW-1:2] == RegDps);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dps_q <= DpsReset;
    end else if (psel && penable && pwrite && sel_dps) begin
      dps_q <= pwdata[DpsW-1:0];
    end
  end

  assign prdata = sel_dps ? {{(32-DpsW){1'b0}}, dps_q} : 32'd0;
  assign dps_o  = dps_q;

endmodule

### hw/rtl/stepper_step_pulse_generator_core.sv
// Stepper step/direction pulse generator, top level.
// Depends on sspg_pkg, sspg_div, sspg_apb.
//
// Usage:
//   Input stream: tuser carries the command (tick, move, stop, enable,
//   disable); tdata carries speed and displacement. Each command yields
//   exactly one status item on the output stream.
//   A tick stands for 10 nanoseconds of the half-period timer.
//   Status: tick, stop, enable and disable give their status in the cycle
//   after acceptance. A move with non-zero speed runs two 34-step serial
//   divisions on the shared divider (steps, then half period) and gives
//   its status from StFin once the output register is free.
//   A move with zero speed is refused at once.
//   Throughput: one command at a time; the next is taken as soon as the
//   block is idle and the output register is free or being drained.
//   A stalled receiver holds the status in the output register; input
//   ready drops until it is taken.
//   Reset: step count, timer and step pin cleared, direction clockwise,
//   driver disabled, degrees-per-step 180 (1.8 degrees).
//   deg_per_step sits at APB byte address 0; write it only when idle.
module stepper_step_pulse_generator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] speed_rpm, [47:16] displacement
  input  logic [sspg_pkg::InDataW-1:0]  s_axis_tdata,
  // [2:0] op
  input  logic [2:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] step_level, [1] direction, [2] enable_n, [3] step_done,
  // [34:4] steps_remaining, [35] busy_res, [36] rejected, [39:37] zero
  output logic [sspg_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sspg_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sspg_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StDivSteps,
    StDivPer,
    StFin
  } state_e;

  state_e            state_q;
  logic [StepW-1:0]  steps_q, steps_d;
  logic              pin_q, pin_d;
  logic              dir_q, dir_d;
  logic              en_n_q, en_n_d;
  logic              run_q, run_d;
  logic [TimerW-1:0] left_q, left_d;
  logic [TimerW-1:0] half_q, half_d;
  logic              done_d, rej_d;

  logic              mdir_q;
  logic [RpmW-1:0]   rpm_q;
  logic [StepW-1:0]  msteps_q;
  logic [TimerW-1:0] mper_q;

  logic              m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  logic [DpsW-1:0]   dps;
  logic [DpsW-1:0]   dps_eff;
  logic              out_free;
  logic              in_acc;
  op_e               op;
  logic [RpmW-1:0]   in_rpm;
  logic [DispW-1:0]  in_disp;
  logic [DispW-1:0]  mag;
  logic [TimerW-1:0] left_dec;
  logic [StepW-1:0]  steps_tmp;
  logic              load_out;

  logic              div_start;
  logic [DivNw-1:0]  div_num;
  logic [DivDw-1:0]  div_den;
  div_res_t          div_res;

  sspg_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dps_o   (dps)
  );

  sspg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .res_o      (div_res)
  );

  assign dps_eff  = (dps == '0) ? DpsW'(1) : dps;
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && out_free;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign op       = op_e'(s_axis_tuser);
  assign in_rpm   = s_axis_tdata[RpmW-1:0];
  assign in_disp  = s_axis_tdata[RpmW +: DispW];
  assign mag      = in_disp[DispW-1] ? (DispW'(0) - in_disp) : in_disp;

  // Divider feed: step count first, then half period.
  always_comb begin
    div_start = 1'b0;
    div_num   = {{(DivNw-DispW){1'b0}}, mag};
    div_den   = {{(DivDw-DpsW){1'b0}}, dps_eff};
    if (in_acc && op == OpMove && in_rpm != '0) begin
      div_start = 1'b1;
    end else if (state_q == StDivSteps && div_res.done) begin
      div_start = 1'b1;
      div_num   = PerNum * DivNw'(dps_eff);
      div_den   = {2'b0, rpm_q} + {1'b0, rpm_q, 1'b0};
    end
  end

  always_comb begin
    steps_d  = steps_q;
    pin_d    = pin_q;
    dir_d    = dir_q;
    en_n_d   = en_n_q;
    run_d    = run_q;
    left_d   = left_q;
    half_d   = half_q;
    done_d   = 1'b0;
    rej_d    = 1'b0;
    load_out = 1'b0;
    left_dec = (left_q == '0) ? left_q : left_q - 1'b1;
    steps_tmp = steps_q;
    if (state_q == StFin) begin
      if (out_free) begin
        load_out = 1'b1;
        dir_d    = mdir_q;
        steps_d  = msteps_q;
        half_d   = mper_q;
        left_d   = mper_q;
        pin_d    = 1'b1;
        run_d    = 1'b1;
      end
    end else if (in_acc) begin
      case (op)
        OpTick: begin
          load_out = 1'b1;
          if (run_q) begin
            left_d = left_dec;
            if (left_dec == '0) begin
              run_d = 1'b0;
              if (!pin_q && steps_q != '0) begin
                steps_tmp = steps_q - 1'b1;
                done_d    = 1'b1;
              end
              steps_d = steps_tmp;
              if (steps_tmp != '0) begin
                pin_d  = !pin_q;
                left_d = half_q;
                run_d  = 1'b1;
              end
            end
          end
        end
        OpMove: begin
          if (in_rpm == '0) begin
            load_out = 1'b1;
            rej_d    = 1'b1;
          end
        end
        OpStop: begin
          load_out = 1'b1;
          run_d    = 1'b0;
          left_d   = '0;
          pin_d    = 1'b0;
          steps_d  = '0;
        end
        OpEnable: begin
          load_out = 1'b1;
          en_n_d   = 1'b0;
        end
        OpDisable: begin
          load_out = 1'b1;
          en_n_d   = 1'b1;
        end
        default: begin
          load_out = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      steps_q   <= '0;
      pin_q     <= 1'b0;
      dir_q     <= 1'b1;
      en_n_q    <= 1'b1;
      run_q     <= 1'b0;
      left_q    <= '0;
      half_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      steps_q <= steps_d;
      pin_q   <= pin_d;
      dir_q   <= dir_d;
      en_n_q  <= en_n_d;
      run_q   <= run_d;
      left_q  <= left_d;
      half_q  <= half_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc && op == OpMove && in_rpm != '0) begin
            state_q <= StDivSteps;
          end
        end
        StDivSteps: begin
          if (div_res.done) begin
            state_q <= StDivPer;
          end
        end
        StDivPer: begin
          if (div_res.done) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Move operands and results; steps and period saturate.
  always_ff @(posedge clk_i) begin
    if (in_acc && op == OpMove) begin
      mdir_q <= !in_disp[DispW-1];
      rpm_q  <= in_rpm;
    end
    if (state_q == StDivSteps && div_res.done) begin
      msteps_q <= (div_res.quot[DivNw-1:StepW] != '0) ? '1 : div_res.quot[StepW-1:0];
    end
    if (state_q == StDivPer && div_res.done) begin
      if (div_res.quot[DivNw-1:TimerW] != '0) begin
        mper_q <= '1;
      end else if (div_res.quot[TimerW-1:0] == '0) begin
        mper_q <= TimerW'(1);
      end else begin
        mper_q <= div_res.quot[TimerW-1:0];
      end
    end
    if (load_out) begin
      m_data_q <= {3'b000, rej_d, run_d, steps_d, done_d, en_n_d, dir_d, pin_d};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  a_idle_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> left_q == '0)
    else $error("timer holds a count while stopped");

  a_run_has_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> half_q != '0)
    else $error("timer running with zero half period");

  a_div_done_in_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == StDivSteps || state_q == StDivPer))
    else $error("divider finished outside a move");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && out_free) |=> (m_axis_tvalid && pin_q && run_q))
    else $error("move completion did not start the timer");
`endif

endmodule

### tb/step_status_checker.sv
`timescale 1ns / 1ps
// Checker for the stepper step/direction pulse generator: watches the command
// and status streams and the APB port, predicts each status item and compares it.
// Depends on sspg_pkg.
module step_status_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // [15:0] speed_rpm, [47:16] displacement
  input  logic [sspg_pkg::InDataW-1:0]  s_axis_tdata,
  // [2:0] op
  input  logic [2:0]                    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] step_level, [1] direction, [2] enable_n, [3] step_done,
  // [34:4] steps_remaining, [35] busy_res, [36] rejected, [39:37] zero
  input  logic [sspg_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sspg_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic [31:0]                   prdata,
  input  logic                          pready,
  output int unsigned                   errors_o,
  output int unsigned                   pending_o
);
  import sspg_pkg::*;

  typedef struct packed {
    logic [2:0]       pad;
    logic             rej;
    logic             busy;
    logic [StepW-1:0] steps;
    logic             done;
    logic             en_n;
    logic             dir;
    logic             level;
  } status_t;

  localparam logic [31:0] StepMax = 32'h7FFF_FFFF;

  status_t          status_q[$];
  int unsigned      err_cnt;
  logic [DpsW-1:0]  dps_q;
  logic [StepW-1:0] step_cnt;
  logic             pin_step;
  logic             pin_dir;
  logic             pin_en_n;
  logic             tmr_run;
  logic [TimerW-1:0] tmr_left;
  logic [TimerW-1:0] half_per;

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    err_cnt++;
    $display("%0t checker: %s expected %0h got %0h", $time, what, want, got);
  endtask

  // Advances the pulse generator by one command, returns the status it reports
  function automatic status_t next_status(logic [2:0] op, logic [RpmW-1:0] rpm,
                                          logic [DispW-1:0] disp);
    status_t     st;
    logic [31:0] dps_eff;
    logic [31:0] mag;
    logic [31:0] steps;
    logic [63:0] per;
    logic        done;
    logic        rej;
    done = 1'b0;
    rej = 1'b0;
    dps_eff = (dps_q == '0) ? 32'd1 : {16'd0, dps_q};
    case (op_e'(op))
      OpTick: begin
        if (tmr_run) begin
          if (tmr_left != '0) tmr_left--;
          if (tmr_left == '0) begin
            tmr_run = 1'b0;
            if (!pin_step && step_cnt != '0) begin
              step_cnt--;
              done = 1'b1;
            end
            if (step_cnt != '0) begin
              pin_step = ~pin_step;
              tmr_left = half_per;
              tmr_run = 1'b1;
            end
          end
        end
      end
      OpMove: begin
        if (rpm == '0) begin
          rej = 1'b1;
        end else begin
          pin_dir = ~disp[31];
          mag = disp[31] ? (32'd0 - disp) : disp;
          steps = mag / dps_eff;
          step_cnt = (steps > StepMax) ? StepMax[StepW-1:0] : steps[StepW-1:0];
          per = (64'd250000 * dps_eff) / (64'd3 * rpm);
          if (per > 64'hFFFF_FFFF) per = 64'hFFFF_FFFF;
          if (per == '0) per = 64'd1;
          half_per = per[TimerW-1:0];
          pin_step = 1'b1;
          tmr_left = half_per;
          tmr_run = 1'b1;
        end
      end
      OpStop: begin
        tmr_run = 1'b0;
        tmr_left = '0;
        pin_step = 1'b0;
        step_cnt = '0;
      end
      OpEnable:  pin_en_n = 1'b0;
      OpDisable: pin_en_n = 1'b1;
      default: ;
    endcase
    st.pad   = '0;
    st.rej   = rej;
    st.busy  = tmr_run;
    st.steps = step_cnt;
    st.done  = done;
    st.en_n  = pin_en_n;
    st.dir   = pin_dir;
    st.level = pin_step;
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    status_t got;
    status_t want;
    if (!rst_ni) begin
      status_q.delete();
      err_cnt = 0;
      dps_q = DpsReset;
      step_cnt = '0;
      pin_step = 1'b0;
      pin_dir = 1'b1;
      pin_en_n = 1'b1;
      tmr_run = 1'b0;
      tmr_left = '0;
      half_per = '0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pready && paddr[ApbAddrW-1:2] == RegDps) begin
        if (pwrite) begin
          dps_q = pwdata[DpsW-1:0];
        end else if (prdata[DpsW-1:0] !== dps_q) begin
          report_mismatch("deg_per_step readback", 64'(dps_q), 64'(prdata[DpsW-1:0]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = status_t'(m_axis_tdata);
        if (status_q.size() == 0) begin
          report_mismatch("status item with none pending", '0, 64'(got));
        end else begin
          want = status_q.pop_front();
          if (got.level !== want.level)
            report_mismatch("step_level", 64'(want.level), 64'(got.level));
          if (got.dir !== want.dir)
            report_mismatch("direction", 64'(want.dir), 64'(got.dir));
          if (got.en_n !== want.en_n)
            report_mismatch("enable_n", 64'(want.en_n), 64'(got.en_n));
          if (got.done !== want.done)
            report_mismatch("step_done", 64'(want.done), 64'(got.done));
          if (got.steps !== want.steps)
            report_mismatch("steps_remaining", 64'(want.steps), 64'(got.steps));
          if (got.busy !== want.busy)
            report_mismatch("busy_res", 64'(want.busy), 64'(got.busy));
          if (got.rej !== want.rej)
            report_mismatch("rejected", 64'(want.rej), 64'(got.rej));
          if (got.pad !== want.pad)
            report_mismatch("padding", 64'(want.pad), 64'(got.pad));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        status_q.push_back(next_status(s_axis_tuser, s_axis_tdata[RpmW-1:0],
                                       s_axis_tdata[RpmW +: DispW]));
      end
      errors_o <= err_cnt;
      pending_o <= status_q.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the stepper step/direction pulse generator: clock, reset,
// command and APB stimulus, receiver stalls and the verdict.
// Depends on sspg_pkg, stepper_step_pulse_generator_core and step_status_checker.
module tb;
  import sspg_pkg::*;

  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [15:0] speed_rpm, [47:16] displacement
  logic [2:0]          s_axis_tuser;   // [2:0] op
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [0] step_level .. [36] rejected, [39:37] zero
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int unsigned         errors;
  int unsigned         pending;

  int unsigned     items_done;
  int unsigned     calm_left;
  bit              hold_rx_req;
  logic [DpsW-1:0] cur_dps;

  stepper_step_pulse_generator_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  step_status_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    #4_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic int unsigned next_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one command and returns at the edge it is taken (or after the gap)
  task automatic send(input logic [2:0] op, input logic [RpmW-1:0] rpm,
                      input logic [DispW-1:0] disp);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {disp, rpm};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op <= OpDisable) items_done++;
    gap = next_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_noise();
    logic [RpmW-1:0] rpm;
    rpm = ($urandom_range(0, 19) == 0) ? '0 : RpmW'($urandom_range(0, 65535));
    send(3'($urandom_range(0, 7)), rpm, $urandom);
  endtask

  // Waits an edge first so that an item taken at the last edge is counted
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_dps(input logic [DpsW-1:0] v);
    logic [15:0] junk;
    drain();
    junk = 16'($urandom_range(0, 65535));
    paddr <= {RegDps, 2'b00};
    pwdata <= {junk, v};
    pwrite <= 1'b1;
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    pwrite <= 1'b0;
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    cur_dps = v;
  endtask

  // A move with a short half period, ticks to carry it through, stop or restart
  task automatic move_run();
    logic [31:0]     d;
    logic [31:0]     disp;
    logic [63:0]     per;
    logic [RpmW-1:0] rpm;
    int unsigned     hp;
    int unsigned     nsteps;
    int unsigned     nticks;
    int unsigned     r;
    d = (cur_dps == '0) ? 32'd1 : {16'd0, cur_dps};
    if ($urandom_range(0, 5) == 0)
      send($urandom_range(0, 1) ? OpEnable : OpDisable, '0, '0);
    per = (64'd250000 * d) / (64'd3 * $urandom_range(1, 6));
    rpm = (per > 64'd65535) ? 16'hFFFF : ((per == '0) ? 16'd1 : per[15:0]);
    r = $urandom_range(0, 99);
    if (r < 8) rpm = RpmW'($urandom_range(0, 65535));
    else if (r < 12) rpm = '0;
    nsteps = $urandom_range(0, 5);
    disp = nsteps * d + $urandom_range(0, d - 1);
    if ($urandom_range(0, 1)) disp = 32'd0 - disp;
    if ($urandom_range(0, 9) == 0) disp = $urandom;
    send(OpMove, rpm, disp);
    if (rpm == '0) begin
      hp = 1;
    end else begin
      per = (64'd250000 * d) / (64'd3 * rpm);
      hp = (per > 64'd120) ? 120 : ((per == '0) ? 1 : int'(per));
    end
    nticks = (2 * nsteps + 2) * hp;
    if (nticks > 120) nticks = 120;
    if ($urandom_range(0, 9) < 3) nticks = $urandom_range(0, nticks);
    repeat (nticks) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_noise();
      else if (r < 5) send(OpStop, RpmW'($urandom_range(0, 65535)), $urandom);
      else send(OpTick, RpmW'($urandom_range(0, 65535)), $urandom);
    end
    if ($urandom_range(0, 1)) send(OpStop, '0, '0);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned goal;
    goal = items_done + count;
    while (items_done < goal) begin
      if ($urandom_range(0, 99) < 85) move_run();
      else repeat ($urandom_range(1, 6)) send_noise();
    end
  endtask

  // Receiver: stretches of ready and stall, one long hold-off on request
  initial begin
    int unsigned left;
    bit          rdy;
    int unsigned r;
    bit          held;
    left = 0;
    rdy = 1'b0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        r = $urandom_range(0, 99);
        if (hold_rx_req && !held) begin
          held = 1'b1;
          rdy = 1'b0;
          left = 400;
        end else if (r < 50) begin
          rdy = 1'b1;
          left = $urandom_range(1, 20);
        end else if (r < 60) begin
          rdy = 1'b1;
          left = $urandom_range(20, 80);
        end else if (r < 90) begin
          rdy = 1'b0;
          left = $urandom_range(1, 4);
        end else if (r < 98) begin
          rdy = 1'b0;
          left = $urandom_range(5, 20);
        end else begin
          rdy = 1'b0;
          left = $urandom_range(40, 120);
        end
      end
      left--;
      m_axis_tready <= rdy;
    end
  end

  initial begin
    items_done = 0;
    calm_left = 0;
    hold_rx_req = 1'b0;
    cur_dps = DpsReset;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting of 1.8 degrees
    send(OpEnable, '0, '0);
    send(OpTick, 16'hFFFF, 32'hFFFF_FFFF);
    send(OpMove, '0, 32'd1000);
    for (int op = OpSpareLo; op <= OpSpareHi; op++) send(3'(op), 16'hFFFF, 32'hFFFF_FFFF);
    send(OpMove, 16'hFFFF, 32'h7FFF_FFFF);
    send(OpMove, 16'd1, 32'h8000_0000);
    send(OpTick, '0, '0);
    send(OpStop, '0, '0);
    send(OpDisable, '0, '0);

    // widest step: half period saturates
    set_dps(16'hFFFF);
    send(OpMove, 16'd1, 32'd1000);
    send(OpTick, '0, '0);
    send(OpStop, '0, '0);

    // step count saturation, then a move of no steps
    set_dps(16'd1);
    send(OpMove, 16'hFFFF, 32'h8000_0000);
    repeat (3) send(OpTick, '0, '0);
    send(OpStop, '0, '0);
    send(OpMove, 16'hFFFF, 32'd0);
    repeat (3) send(OpTick, '0, '0);

    run_random(300);
    set_dps(16'd0);
    run_random(200);
    set_dps(16'd36000);
    run_random(80);
    set_dps(DpsW'($urandom_range(2, 9)));
    hold_rx_req = 1'b1;
    run_random(350);

    drain();
    repeat (80) @(posedge clk_i);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sspg_pkg.sv
hw/rtl/sspg_div.sv
hw/rtl/sspg_apb.sv
hw/rtl/stepper_step_pulse_generator_core.sv
tb/step_status_checker.sv
tb/tb.sv
